### design/cps_pkg.sv
// Shared types, constants and register codes for the clamped PID step block.
package cps_pkg;

    // Loop update rate used by the integral and derivative scaling
    localparam int STEPS_PER_SECOND = 50;

    // Field and state widths
    localparam int DATA_W     = 16;
    localparam int ERR_W      = DATA_W + 1;
    localparam int SUM_W      = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Drive returned when the setpoint lies below the measured value
    localparam logic [DATA_W-1:0] FALLBACK_DRIVE = 16'd13;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd3;

    localparam logic [DATA_W-1:0] PERIOD_RESET = 16'd1000;

    // Integral quotient by reciprocal: x < STEPS * 2^16 always holds when it is used
    localparam int     X_W         = $clog2(STEPS_PER_SECOND * 65536);
    localparam int     LIM_W       = X_W + 1;
    localparam int     RECIP_SHIFT = X_W + $clog2(STEPS_PER_SECOND);
    localparam longint RECIP       = ((longint'(1) << RECIP_SHIFT) + STEPS_PER_SECOND - 1)
                                     / STEPS_PER_SECOND;
    localparam int     RECIP_W     = $clog2(RECIP + 1);

    // Derivative difference scaled by the rate
    localparam int STEP_W  = $clog2(STEPS_PER_SECOND + 1);
    localparam int DIFFD_W = ERR_W + STEP_W;

    // Shared multiplier operand and product widths
    localparam int MUL_A_W0 = (DIFFD_W > 32) ? DIFFD_W : 32;
    localparam int MUL_A_W  = (X_W + 1 > MUL_A_W0) ? X_W + 1 : MUL_A_W0;
    localparam int MUL_B_W0 = (RECIP_W + 1 > ERR_W) ? RECIP_W + 1 : ERR_W;
    localparam int MUL_B_W  = (STEP_W + 1 > MUL_B_W0) ? STEP_W + 1 : MUL_B_W0;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    // Configuration register set
    typedef struct packed {
        logic signed [DATA_W-1:0] gain_p;
        logic signed [DATA_W-1:0] gain_i;
        logic signed [DATA_W-1:0] gain_d;
        logic        [DATA_W-1:0] period;
    } cfg_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P,
        ST_I,
        ST_IDIV,
        ST_D1,
        ST_D2,
        ST_DCL,
        ST_TOT,
        ST_DONE
    } state_t;

endpackage

### design/cps_in_if.sv
// Input channel carrying one measured value and setpoint per beat.
interface cps_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [cps_pkg::DATA_W-1:0] measured;
    logic signed [cps_pkg::DATA_W-1:0] setpoint;

    modport source (output valid, output measured, output setpoint, input ready);
    modport sink   (input valid, input measured, input setpoint, output ready);
endinterface

### design/cps_out_if.sv
// Output channel carrying one drive value and flag per beat.
interface cps_out_if;
    logic                        valid;
    logic                        ready;
    logic [cps_pkg::DATA_W-1:0]  drive;
    logic                        error_negative;

    modport source (output valid, output drive, output error_negative, input ready);
    modport sink   (input valid, input drive, input error_negative, output ready);
endinterface

### design/cps_cfg.sv
// Configuration register file: gains and drive period.
module cps_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cps_pkg::CFG_DATA_W-1:0]    cfg_data,
    output cps_pkg::cfg_t                     cfg
);

    cps_pkg::cfg_t cfg_reg;
    cps_pkg::cfg_t cfg_next;

    // Decode the write; unknown indexes drop the beat
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                cps_pkg::CFG_GAIN_P: cfg_next.gain_p = cfg_data;
                cps_pkg::CFG_GAIN_I: cfg_next.gain_i = cfg_data;
                cps_pkg::CFG_GAIN_D: cfg_next.gain_d = cfg_data;
                cps_pkg::CFG_PERIOD: cfg_next.period = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p <= '0;
            cfg_reg.gain_i <= '0;
            cfg_reg.gain_d <= '0;
            cfg_reg.period <= cps_pkg::PERIOD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/cps_mul.sv
// Shared signed multiplier with a registered product.
module cps_mul (
    input  logic                                 clk,
    input  logic signed [cps_pkg::MUL_A_W-1:0]   a,
    input  logic signed [cps_pkg::MUL_B_W-1:0]   b,
    output logic signed [cps_pkg::PROD_W-1:0]    prod_reg
);

    logic signed [cps_pkg::PROD_W-1:0] prod_next;

    // Full-width signed product
    always_comb
    begin
        prod_next = a * b;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

### design/clamped_pid_step.sv
// Each accepted beat steps through states P, I, IDIV, D1, D2, DCL and TOT to DONE; a negative
// error goes straight to DONE. Five passes go through the one shared multiplier. A new item
// is taken only once DONE has moved its result into the output register.
// A finished result waits in the output register while the next item is taken.
// Reset: asynchronous, active low; clears error sum, last error, output valid and the
// sequencer, loads gains with 0 and the period with 1000.
module clamped_pid_step (
    input  logic                              clk,
    input  logic                              rst_n,
    cps_in_if.sink                            req,
    cps_out_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [cps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cps_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int DW  = cps_pkg::DATA_W;
    localparam int EW  = cps_pkg::ERR_W;
    localparam int SW  = cps_pkg::SUM_W;
    localparam int AW  = cps_pkg::MUL_A_W;
    localparam int BW  = cps_pkg::MUL_B_W;
    localparam int PW  = cps_pkg::PROD_W;
    localparam int XW  = cps_pkg::X_W;
    localparam int LW  = cps_pkg::LIM_W;
    localparam int DDW = cps_pkg::DIFFD_W;

    // Clamp a signed product to 0..hi
    function automatic logic [DW-1:0] clamp_term(input logic signed [PW-1:0] v,
                                                 input logic [DW-1:0] hi);
        logic [DW-1:0] r;
        if (v[PW-1])
            r = '0;
        else if ($unsigned(v) > PW'(hi))
            r = hi;
        else
            r = v[DW-1:0];
        return r;
    endfunction

    cps_pkg::cfg_t cfg;

    cps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] prod;

    cps_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod)
    );

    cps_pkg::state_t      state_reg,      state_next;
    logic [SW-1:0]        sum_reg,        sum_next;
    logic [DW-1:0]        last_reg,       last_next;
    logic [DW-1:0]        err_reg,        err_next;
    logic signed [EW-1:0] diff_reg,       diff_next;
    logic [LW-1:0]        lim_reg,        lim_next;
    logic                 i_neg_reg,      i_neg_next;
    logic                 i_high_reg,     i_high_next;
    logic [DW-1:0]        p_term_reg,     p_term_next;
    logic [DW-1:0]        i_term_reg,     i_term_next;
    logic [DW-1:0]        d_term_reg,     d_term_next;
    logic [DW-1:0]        res_drive_reg,  res_drive_next;
    logic                 res_neg_reg,    res_neg_next;
    logic                 out_valid_reg,  out_valid_next;
    logic [DW-1:0]        out_drive_reg,  out_drive_next;
    logic                 out_neg_reg,    out_neg_next;

    logic                 accept;
    logic                 out_free;
    logic                 out_load;
    logic signed [EW-1:0] err_full;
    logic [SW:0]          sum_add;
    logic [DW+1:0]        total;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign out_load = (state_reg == cps_pkg::ST_DONE) && out_free;

    assign err_full = {req.setpoint[DW-1], req.setpoint} - {req.measured[DW-1], req.measured};
    assign sum_add  = {1'b0, sum_reg} + (SW + 1)'(err_full[DW-1:0]);
    assign total    = (DW + 2)'(p_term_reg) + (DW + 2)'(i_term_reg) + (DW + 2)'(d_term_reg);

    // Sequence the multiplier passes and clamp each term
    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        last_next      = last_reg;
        err_next       = err_reg;
        diff_next      = diff_reg;
        lim_next       = lim_reg;
        i_neg_next     = i_neg_reg;
        i_high_next    = i_high_reg;
        p_term_next    = p_term_reg;
        i_term_next    = i_term_reg;
        d_term_next    = d_term_reg;
        res_drive_next = res_drive_reg;
        res_neg_next   = res_neg_reg;
        mul_a          = '0;
        mul_b          = '0;

        unique case (state_reg)
            cps_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    lim_next = LW'(cps_pkg::STEPS_PER_SECOND) * (LW'(cfg.period) + LW'(1));
                    if (err_full[EW-1])
                    begin
                        sum_next       = '0;
                        last_next      = '0;
                        res_drive_next = cps_pkg::FALLBACK_DRIVE;
                        res_neg_next   = 1'b1;
                        state_next     = cps_pkg::ST_DONE;
                    end
                    else
                    begin
                        err_next     = err_full[DW-1:0];
                        sum_next     = sum_add[SW] ? {SW{1'b1}} : sum_add[SW-1:0];
                        diff_next    = err_full - $signed({1'b0, last_reg});
                        last_next    = err_full[DW-1:0];
                        res_neg_next = 1'b0;
                        state_next   = cps_pkg::ST_P;
                    end
                end
            end
            cps_pkg::ST_P:
            begin
                mul_a      = AW'(err_reg);
                mul_b      = BW'(cfg.gain_p);
                state_next = cps_pkg::ST_I;
            end
            cps_pkg::ST_I:
            begin
                mul_a       = AW'(sum_reg);
                mul_b       = BW'(cfg.gain_i);
                p_term_next = clamp_term(prod, cfg.period);
                state_next  = cps_pkg::ST_IDIV;
            end
            cps_pkg::ST_IDIV:
            begin
                // Quotient by reciprocal; range decision kept alongside
                mul_a       = AW'(prod[XW-1:0]);
                mul_b       = BW'(cps_pkg::RECIP);
                i_neg_next  = prod[PW-1];
                i_high_next = $unsigned(prod) >= PW'(lim_reg);
                state_next  = cps_pkg::ST_D1;
            end
            cps_pkg::ST_D1:
            begin
                mul_a = {{(AW - EW){diff_reg[EW-1]}}, diff_reg};
                mul_b = BW'(cps_pkg::STEPS_PER_SECOND);
                if (i_neg_reg)
                    i_term_next = '0;
                else if (i_high_reg)
                    i_term_next = cfg.period;
                else
                    i_term_next = prod[cps_pkg::RECIP_SHIFT +: DW];
                state_next = cps_pkg::ST_D2;
            end
            cps_pkg::ST_D2:
            begin
                mul_a      = {{(AW - DDW){prod[DDW-1]}}, prod[DDW-1:0]};
                mul_b      = BW'(cfg.gain_d);
                state_next = cps_pkg::ST_DCL;
            end
            cps_pkg::ST_DCL:
            begin
                d_term_next = clamp_term(prod, cfg.period);
                state_next  = cps_pkg::ST_TOT;
            end
            cps_pkg::ST_TOT:
            begin
                res_drive_next = (total > (DW + 2)'(cfg.period)) ? cfg.period : total[DW-1:0];
                state_next     = cps_pkg::ST_DONE;
            end
            cps_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = cps_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cps_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register: load a finished result, drop it once taken
    always_comb
    begin
        out_valid_next = out_load || (out_valid_reg && !rsp.ready);
        out_drive_next = out_load ? res_drive_reg : out_drive_reg;
        out_neg_next   = out_load ? res_neg_reg : out_neg_reg;
    end

    // Control and loop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cps_pkg::ST_IDLE;
            sum_reg       <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        err_reg       <= err_next;
        diff_reg      <= diff_next;
        lim_reg       <= lim_next;
        i_neg_reg     <= i_neg_next;
        i_high_reg    <= i_high_next;
        p_term_reg    <= p_term_next;
        i_term_reg    <= i_term_next;
        d_term_reg    <= d_term_next;
        res_drive_reg <= res_drive_next;
        res_neg_reg   <= res_neg_next;
        out_drive_reg <= out_drive_next;
        out_neg_reg   <= out_neg_next;
    end

    assign req.ready          = (state_reg == cps_pkg::ST_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.drive          = out_drive_reg;
    assign rsp.error_negative = out_neg_reg;

    // A result from the PID terms never exceeds the period
    a_drive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_neg_reg) |-> (out_drive_reg <= cfg.period))
        else $error("drive above period");

    // A flagged result carries the fallback drive
    a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_neg_reg) |-> (out_drive_reg == cps_pkg::FALLBACK_DRIVE))
        else $error("flagged result without fallback drive");

    // A negative error clears the loop state
    a_neg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && err_full[EW-1]) |=> (sum_reg == '0 && last_reg == '0))
        else $error("state not cleared on negative error");

    // An accepted beat starts work
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != cps_pkg::ST_IDLE))
        else $error("sequencer idle after accept");

endmodule

### tb/testbench.sv
// Self-checking testbench for the clamped PID step block: directed steps, back-to-back, random.
`timescale 1ns / 1ps

module testbench;

    // Package constants used here
    localparam int DATA_W           = cps_pkg::DATA_W;
    localparam int CFG_IDX_W        = cps_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W       = cps_pkg::CFG_DATA_W;
    localparam int STEPS_PER_SECOND = cps_pkg::STEPS_PER_SECOND;
    localparam logic [DATA_W-1:0] PERIOD_RESET   = cps_pkg::PERIOD_RESET;
    localparam logic [DATA_W-1:0] FALLBACK_DRIVE = cps_pkg::FALLBACK_DRIVE;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P  = cps_pkg::CFG_GAIN_P;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I  = cps_pkg::CFG_GAIN_I;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D  = cps_pkg::CFG_GAIN_D;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = cps_pkg::CFG_PERIOD;

    // Run shape
    localparam int RESET_CYCLES     = 6;
    localparam int SETTLE_CYCLES    = 10;
    localparam int TAIL_CYCLES      = 20;
    localparam int QUIET_LIMIT      = 5000;
    localparam int MAX_BURST        = 16;
    localparam int MAX_GAP          = 12;
    localparam int STEADY_SAMPLES   = 200;
    localparam int RANDOM_PHASES    = 8;
    localparam int PHASE_SAMPLES    = 225;
    localparam int HOLD_AT_FIRST    = 100;
    localparam int HOLD_AT_SECOND   = 1500;
    localparam int HOLD_CYCLES      = 400;
    localparam int REPORT_LIMIT     = 10;

    localparam longint SUM_CEILING  = 64'sd2147483647;

    // Register indexes that decode to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_FIRST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONE_LAST  = 3'd7;

    localparam logic [DATA_W-1:0] GAIN_MAX   = 16'h7FFF;
    localparam logic [DATA_W-1:0] GAIN_MIN   = 16'h8000;
    localparam logic [DATA_W-1:0] PERIOD_MAX = 16'hFFFF;

    typedef enum logic {ROW_SAMPLE, ROW_REG} row_kind_t;
    typedef enum logic [1:0] {RS_OPEN, RS_HALF, RS_SPARSE, RS_ALTERNATE} ready_style_t;

    typedef struct {
        row_kind_t                 kind;
        logic [CFG_IDX_W-1:0]      reg_index;
        logic [CFG_DATA_W-1:0]     reg_value;
        logic signed [DATA_W-1:0]  measured;
        logic signed [DATA_W-1:0]  setpoint;
        bit                        typed;
        logic [DATA_W-1:0]         drive;
        logic                      error_negative;
    } step_row_t;

    typedef struct packed {
        logic [DATA_W-1:0] drive;
        logic              error_negative;
    } pid_result_t;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    cps_in_if  req_ch ();
    cps_out_if rsp_ch ();

    clamped_pid_step i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Controller state as the block should hold it
    logic signed [DATA_W-1:0] kp = '0;
    logic signed [DATA_W-1:0] ki = '0;
    logic signed [DATA_W-1:0] kd = '0;
    logic        [DATA_W-1:0] period_lim = PERIOD_RESET;
    longint                   acc_sum = 0;
    longint                   prev_err = 0;

    pid_result_t pending_results[$];
    step_row_t   directed_steps[$];

    bit offering;
    bit steady_feed;
    int burst_left;
    int samples_sent;
    int results_seen;
    int mismatch_count;
    int fallback_count;
    int ceiling_hits;
    int setting_count;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Clamp one value to 0..period
    function automatic longint clip_to_period(input longint v);
        longint lim;
        lim = period_lim;
        if (v > lim)
            return lim;
        if (v < 0)
            return 0;
        return v;
    endfunction

    // Advance the controller by one sample and give the drive it produces
    function automatic void pid_update(input logic signed [DATA_W-1:0] meas,
                                       input logic signed [DATA_W-1:0] sp,
                                       output logic [DATA_W-1:0] drive,
                                       output logic neg);
        longint err, gp, gi, gd, p, i, d, total;
        gp  = kp;
        gi  = ki;
        gd  = kd;
        err = longint'(sp) - longint'(meas);
        if (err < 0)
        begin
            acc_sum  = 0;
            prev_err = 0;
            drive    = FALLBACK_DRIVE;
            neg      = 1'b1;
            fallback_count++;
        end
        else
        begin
            acc_sum = acc_sum + err;
            if (acc_sum > SUM_CEILING)
            begin
                acc_sum = SUM_CEILING;
                ceiling_hits++;
            end
            p     = clip_to_period(gp * err);
            i     = clip_to_period((gi * acc_sum) / STEPS_PER_SECOND);
            d     = clip_to_period(gd * (err - prev_err) * STEPS_PER_SECOND);
            total = clip_to_period(p + i + d);
            prev_err = err;
            drive    = total[DATA_W-1:0];
            neg      = 1'b0;
        end
    endfunction

    // Build the directed script
    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
        step_row_t row;
        row = '{ROW_REG, idx, val, '0, '0, 1'b0, '0, 1'b0};
        directed_steps.push_back(row);
    endfunction

    function automatic void add_sample(input logic signed [DATA_W-1:0] m,
                                       input logic signed [DATA_W-1:0] s);
        step_row_t row;
        row = '{ROW_SAMPLE, '0, '0, m, s, 1'b0, '0, 1'b0};
        directed_steps.push_back(row);
    endfunction

    function automatic void add_known(input logic signed [DATA_W-1:0] m,
                                      input logic signed [DATA_W-1:0] s,
                                      input logic [DATA_W-1:0] drv,
                                      input logic neg);
        step_row_t row;
        row = '{ROW_SAMPLE, '0, '0, m, s, 1'b1, drv, neg};
        directed_steps.push_back(row);
    endfunction

    function automatic logic [DATA_W-1:0] pick_gain();
        int v;
        case ($urandom_range(0, 4))
            0: return GAIN_MAX;
            1: return GAIN_MIN;
            2: return 16'($urandom_range(0, 64));
            3:
            begin
                v = int'($urandom_range(0, 128)) - 64;
                return v[DATA_W-1:0];
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_period();
        case ($urandom_range(0, 5))
            0: return PERIOD_MAX;
            1: return 16'd1;
            2: return 16'd0;
            3: return 16'($urandom_range(1, 2000));
            4: return 16'($urandom_range(13, 200));
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one sample, pacing the sender in bursts, and log what it should produce
    task automatic feed_sample(input logic signed [DATA_W-1:0] m,
                               input logic signed [DATA_W-1:0] s,
                               input bit typed,
                               input logic [DATA_W-1:0] typed_drive,
                               input logic typed_neg);
        int gap;
        logic [DATA_W-1:0] drv;
        logic neg;
        pid_result_t want;
        if (!steady_feed && burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            if (gap > 0 && offering)
            begin
                req_ch.valid <= 1'b0;
                offering = 1'b0;
            end
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, MAX_BURST);
        end
        burst_left--;
        req_ch.valid    <= 1'b1;
        req_ch.measured <= m;
        req_ch.setpoint <= s;
        offering = 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        pid_update(m, s, drv, neg);
        if (typed)
        begin
            drv = typed_drive;
            neg = typed_neg;
        end
        want.drive          = drv;
        want.error_negative = neg;
        pending_results.push_back(want);
        samples_sent++;
    endtask

    // Drop valid and wait until every beat in flight has come out
    task automatic settle_block();
        if (offering)
        begin
            req_ch.valid <= 1'b0;
            offering = 1'b0;
        end
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    // One register write; the caller lowers the enable after the last one
    task automatic reg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_GAIN_P: kp = val;
            CFG_GAIN_I: ki = val;
            CFG_GAIN_D: kd = val;
            CFG_PERIOD: period_lim = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [DATA_W-1:0] gp, input logic [DATA_W-1:0] gi,
                                 input logic [DATA_W-1:0] gd, input logic [DATA_W-1:0] per);
        settle_block();
        reg_write(CFG_GAIN_P, gp);
        reg_write(CFG_GAIN_I, gi);
        reg_write(CFG_GAIN_D, gd);
        reg_write(CFG_PERIOD, per);
        if ($urandom_range(0, 2) == 0)
            reg_write(3'($urandom_range(CFG_NONE_FIRST, CFG_NONE_LAST)), 16'($urandom));
        cfg_we <= 1'b0;
        setting_count++;
    endtask

    // Compare one result beat with the oldest expectation
    task automatic check_result();
        pid_result_t want;
        results_seen++;
        if (pending_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("unexpected result beat: drive %0d flag %0b",
                         rsp_ch.drive, rsp_ch.error_negative);
        end
        else
        begin
            want = pending_results.pop_front();
            if (rsp_ch.drive !== want.drive || rsp_ch.error_negative !== want.error_negative)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("result %0d: drive exp %0d got %0d, flag exp %0b got %0b",
                             results_seen, want.drive, rsp_ch.drive,
                             want.error_negative, rsp_ch.error_negative);
            end
        end
    endtask

    // Result side: check beats and stall in stretches of changing style
    initial
    begin : result_sink
        ready_style_t style;
        int stretch_left;
        bit take;
        bit got_beat;
        style = RS_OPEN;
        stretch_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            got_beat = rsp_ch.valid && rsp_ch.ready;
            if (got_beat)
                check_result();
            // hold off long enough for the block to back up onto its input
            if (got_beat && (results_seen == HOLD_AT_FIRST || results_seen == HOLD_AT_SECOND))
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (stretch_left <= 0)
            begin
                style = ready_style_t'($urandom_range(0, 3));
                stretch_left = $urandom_range(5, 60);
            end
            stretch_left--;
            case (style)
                RS_OPEN:   take = 1'b1;
                RS_HALF:   take = 1'($urandom_range(0, 1));
                RS_SPARSE: take = ($urandom_range(0, 3) == 0);
                default:   take = !rsp_ch.ready;
            endcase
            if (steady_feed)
                take = 1'b1;
            rsp_ch.ready <= take;
        end
    end

    // End the run when nothing moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("clamped_pid_step: mismatch");
        $finish;
    end

    // Stimulus
    initial
    begin : stimulus
        int ph;
        int n;
        int e;
        int base;
        logic signed [DATA_W-1:0] m;
        logic signed [DATA_W-1:0] s;

        req_ch.valid    <= 1'b0;
        req_ch.measured <= '0;
        req_ch.setpoint <= '0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        rst_n           <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values: zero gains give zero drive; setpoint below measured falls back
        add_known(16'sd0, 16'sd0, 16'd0, 1'b0);
        add_known(-16'sd32768, 16'sd32767, 16'd0, 1'b0);
        add_known(16'sd32767, -16'sd32768, FALLBACK_DRIVE, 1'b1);
        // Largest gains and period
        add_reg(CFG_GAIN_P, GAIN_MAX);
        add_reg(CFG_GAIN_I, GAIN_MAX);
        add_reg(CFG_GAIN_D, GAIN_MAX);
        add_reg(CFG_PERIOD, PERIOD_MAX);
        add_known(-16'sd32768, 16'sd32767, PERIOD_MAX, 1'b0);
        add_sample(16'sd0, 16'sd1);
        add_sample(16'sd100, 16'sd100);
        // Most negative gains clamp every term to zero
        add_reg(CFG_GAIN_P, GAIN_MIN);
        add_reg(CFG_GAIN_I, GAIN_MIN);
        add_reg(CFG_GAIN_D, GAIN_MIN);
        add_known(16'sd0, 16'sd5, 16'd0, 1'b0);
        add_known(16'sd10, 16'sd0, FALLBACK_DRIVE, 1'b1);
        add_known(16'sd0, 16'sd0, 16'd0, 1'b0);
        // Zero period forces zero drive, fallback still gives its fixed value
        add_reg(CFG_GAIN_P, GAIN_MAX);
        add_reg(CFG_GAIN_I, GAIN_MAX);
        add_reg(CFG_GAIN_D, GAIN_MAX);
        add_reg(CFG_PERIOD, 16'd0);
        add_known(-16'sd500, 16'sd500, 16'd0, 1'b0);
        add_known(16'sd32767, -16'sd32768, FALLBACK_DRIVE, 1'b1);
        // Period below the fallback value
        add_reg(CFG_PERIOD, 16'd5);
        add_known(16'sd0, 16'sd3, 16'd5, 1'b0);
        add_known(16'sd1, 16'sd0, FALLBACK_DRIVE, 1'b1);
        // Writes to undecoded indexes leave every register alone
        add_reg(CFG_NONE_FIRST, 16'd0);
        add_reg(3'(CFG_NONE_FIRST + 1), 16'd0);
        add_reg(3'(CFG_NONE_LAST - 1), 16'd0);
        add_reg(CFG_NONE_LAST, 16'd0);
        add_known(16'sd0, 16'sd2, 16'd5, 1'b0);
        // Each term on its own
        add_reg(CFG_GAIN_P, 16'd1);
        add_reg(CFG_GAIN_I, 16'd0);
        add_reg(CFG_GAIN_D, 16'd0);
        add_reg(CFG_PERIOD, PERIOD_RESET);
        add_known(16'sd0, 16'sd500, 16'd500, 1'b0);
        add_known(-16'sd1000, 16'sd500, PERIOD_RESET, 1'b0);
        add_reg(CFG_GAIN_P, 16'd0);
        add_reg(CFG_GAIN_I, 16'd50);
        add_sample(16'sd0, 16'sd7);
        add_reg(CFG_GAIN_I, 16'd0);
        add_reg(CFG_GAIN_D, 16'd1);
        add_sample(16'sd0, 16'sd3);
        add_sample(16'sd0, 16'sd10);
        add_reg(CFG_GAIN_I, 16'hFFFF);
        add_reg(CFG_GAIN_D, 16'd0);
        add_sample(16'sd0, 16'sd99);

        // Walk the script; registers change only with the block drained
        foreach (directed_steps[r])
        begin
            if (directed_steps[r].kind == ROW_REG)
            begin
                if (r == 0 || directed_steps[r-1].kind != ROW_REG)
                    settle_block();
                reg_write(directed_steps[r].reg_index, directed_steps[r].reg_value);
                if (r + 1 == directed_steps.size() || directed_steps[r+1].kind != ROW_REG)
                    cfg_we <= 1'b0;
            end
            else
                feed_sample(directed_steps[r].measured, directed_steps[r].setpoint,
                            directed_steps[r].typed, directed_steps[r].drive,
                            directed_steps[r].error_negative);
        end

        // Grow the error sum with the largest error, back to back
        load_settings(16'd0, 16'd1, 16'd0, PERIOD_MAX);
        steady_feed = 1'b1;
        for (n = 0; n < STEADY_SAMPLES; n++)
            feed_sample(-16'sd32768, 16'sd32767, 1'b0, '0, 1'b0);
        settle_block();
        steady_feed = 1'b0;

        // Random phases, the first two at the extremes
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 0)
                load_settings(GAIN_MAX, GAIN_MAX, GAIN_MAX, PERIOD_MAX);
            else if (ph == 1)
                load_settings(GAIN_MIN, GAIN_MIN, GAIN_MIN, 16'd1);
            else
                load_settings(pick_gain(), pick_gain(), pick_gain(), pick_period());
            for (n = 0; n < PHASE_SAMPLES; n++)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    // setpoint below measured: clears the loop state
                    e = $urandom_range(0, 1) ? $urandom_range(1, 20) : $urandom_range(1, 65535);
                    base = -32768 + e + int'($urandom_range(0, 65535 - e));
                    m = 16'(base);
                    s = 16'(base - e);
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       e = $urandom_range(0, 20);
                        1:       e = $urandom_range(0, 2000);
                        2:       e = $urandom_range(0, 65535);
                        default: e = 65535 - int'($urandom_range(0, 20));
                    endcase
                    base = -32768 + int'($urandom_range(0, 65535 - e));
                    m = 16'(base);
                    s = 16'(base + e);
                end
                feed_sample(m, s, 1'b0, '0, 1'b0);
            end
        end

        settle_block();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d samples under %0d register settings: %0d fallbacks, %0d ceiling hits.",
                 samples_sent, setting_count, fallback_count, ceiling_hits);
        $display("Checked %0d result beats, %0d disagreed.", results_seen, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("clamped_pid_step: match");
        else
            $display("clamped_pid_step: mismatch");
        $finish;
    end

endmodule

### sim.f
design/cps_pkg.sv
design/cps_in_if.sv
design/cps_out_if.sv
design/cps_cfg.sv
design/cps_mul.sv
design/clamped_pid_step.sv
tb/testbench.sv
